FILE: sv/assert_macros.svh
// Assertion macros for the checker file of the DNS responder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define CDR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: sv/cdr_pkg.sv
// Shared types, constants and the answer record table of the DNS responder.
package cdr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] QR_BIT = 8'h80;
    localparam logic [7:0] AA_BIT = 8'h04;
    localparam logic [7:0] RA_BIT = 8'h80;
    localparam logic [7:0] PTR_HI = 8'hC0;
    localparam logic [7:0] PTR_LO = 8'h0C;
    localparam logic [7:0] ANSWER_TTL = 8'd60;
    localparam logic [7:0] RDATA_LEN = 8'h04;
    localparam int HEADER_LEN = 12;
    localparam int ANSWER_LEN = 16;

    typedef struct packed {
        logic       keep;
        logic [7:0] data;
        logic       last;
        logic       drop;
    } cdr_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cdr_qstat_t;

    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = PTR_HI;
            4'd1:    b = PTR_LO;
            4'd3:    b = 8'd1;
            4'd5:    b = 8'd1;
            4'd9:    b = ANSWER_TTL;
            4'd11:   b = RDATA_LEN;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/cdr_front.sv
// Front end: parses the DNS query bytes, rewrites the header and gives the verdict.
module cdr_front #(
    parameter int MAX_PACKET = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             push,
    output cdr_pkg::cdr_rec_t rec
);
    import cdr_pkg::*;

    localparam int CW = $clog2(MAX_PACKET + 7);

    typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_TAIL} phase_t;

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] qend_reg, qend_next;
    logic [7:0]  label_reg, label_next;
    logic [7:0]  qd_reg, qd_next;
    logic        reject_reg, reject_next;
    logic        keep;
    logic [7:0]  obyte;
    logic        drop;
    logic        accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        qend_next   = qend_reg;
        label_next  = label_reg;
        qd_next     = qd_reg;
        reject_next = reject_reg;
        keep        = 1'b0;
        obyte       = in_byte;
        if (count_reg < CW'(MAX_PACKET))
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    keep = 1'b1;
                    if (count_reg == CW'(2))
                    begin
                        if (in_byte[7])
                        begin
                            reject_next = 1'b1;
                        end
                        obyte = in_byte | QR_BIT | AA_BIT;
                    end
                    else if (count_reg == CW'(3))
                    begin
                        obyte = in_byte | RA_BIT;
                    end
                    else if (count_reg == CW'(4))
                    begin
                        qd_next = in_byte;
                    end
                    else if (count_reg == CW'(5))
                    begin
                        if ({qd_reg, in_byte} != 16'd1)
                        begin
                            reject_next = 1'b1;
                        end
                    end
                    else if (count_reg == CW'(6))
                    begin
                        obyte = 8'd0;
                    end
                    else if (count_reg == CW'(7))
                    begin
                        obyte = 8'd1;
                    end
                    if (count_reg == CW'(HEADER_LEN - 1))
                    begin
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    keep = 1'b1;
                    if (label_reg != 8'd0)
                    begin
                        label_next = label_reg - 8'd1;
                    end
                    else if (in_byte == 8'd0)
                    begin
                        qend_next  = count_reg + CW'(5);
                        phase_next = PH_TAIL;
                    end
                    else if ((in_byte & PTR_HI) == PTR_HI)
                    begin
                        qend_next  = count_reg + CW'(6);
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        label_next = in_byte;
                    end
                end
                PH_TAIL:
                begin
                    keep = count_reg < qend_reg;
                end
                default:
                begin
                    keep = 1'b0;
                end
            endcase
            count_next = count_reg + CW'(1);
        end
        drop = reject_next || (count_next < CW'(HEADER_LEN)) || (phase_next != PH_TAIL) ||
               (qend_next > count_next) ||
               (({1'b0, qend_next} + (CW + 1)'(ANSWER_LEN)) > (CW + 1)'(MAX_PACKET));
    end

    assign push      = accept && (keep || in_last);
    assign rec.keep  = keep;
    assign rec.data  = obyte;
    assign rec.last  = in_last;
    assign rec.drop  = drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            qend_reg   <= '0;
            label_reg  <= '0;
            qd_reg     <= '0;
            reject_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                phase_reg  <= PH_HEADER;
                count_reg  <= '0;
                qend_reg   <= '0;
                label_reg  <= '0;
                qd_reg     <= '0;
                reject_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                qend_reg   <= qend_next;
                label_reg  <= label_next;
                qd_reg     <= qd_next;
                reject_reg <= reject_next;
            end
        end
    end

endmodule

FILE: sv/cdr_queue.sv
// Short queue of classified records between the front end and the back end.
module cdr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cdr_pkg::cdr_rec_t wdata,
    input  logic              pop,
    output cdr_pkg::cdr_rec_t rdata,
    output cdr_pkg::cdr_qstat_t status
);
    import cdr_pkg::*;

    cdr_rec_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/cdr_back.sv
// Back end: sends passed bytes, then the drop mark or the appended A answer.
module cdr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cdr_pkg::cdr_rec_t   rec,
    input  cdr_pkg::cdr_qstat_t qstat,
    output logic                pop,
    input  logic [31:0]         address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                drop
);
    import cdr_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       drop_reg, drop_next;
    logic       ans_reg, ans_next;
    logic [3:0] idx_reg, idx_next;
    logic       pend_reg, pend_next;
    logic       adv;

    assign adv = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        ans_next   = ans_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        pop        = 1'b0;
        if (adv)
        begin
            valid_next = 1'b1;
            drop_next  = 1'b0;
            last_next  = 1'b0;
            if (ans_reg)
            begin
                byte_next = answer_byte(idx_reg, address);
                last_next = idx_reg == 4'd15;
                idx_next  = idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                begin
                    ans_next = 1'b0;
                end
            end
            else if (pend_reg)
            begin
                byte_next = 8'd0;
                last_next = 1'b1;
                drop_next = 1'b1;
                pend_next = 1'b0;
            end
            else if (!qstat.empty)
            begin
                pop = 1'b1;
                if (rec.keep)
                begin
                    byte_next = rec.data;
                    if (rec.last)
                    begin
                        if (rec.drop)
                        begin
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            ans_next = 1'b1;
                            idx_next = 4'd0;
                        end
                    end
                end
                else if (rec.drop)
                begin
                    byte_next = 8'd0;
                    last_next = 1'b1;
                    drop_next = 1'b1;
                end
                else
                begin
                    byte_next = answer_byte(4'd0, address);
                    ans_next  = 1'b1;
                    idx_next  = 4'd1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            drop_reg  <= 1'b0;
            ans_reg   <= 1'b0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            drop_reg  <= drop_next;
            ans_reg   <= ans_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign drop      = drop_reg;

endmodule

FILE: sv/captive_dns_responder.sv
// Top level of the captive DNS responder: register port, front end, queue and back end.
//
//  channel   direction  transfer when          payload
//  input     in         in_valid && !in_stall  in_byte, in_last
//  output    out        out_valid && !out_stall out_byte, out_last, drop
//  config    in         psel&penable&pwrite    paddr, pwdata (APB write)
//
// One input byte is taken every cycle while the four-entry queue has room.
// A passed byte is queued and, when the back end pops it, moves to the output register.
// The final byte of a good query produces up to seventeen results, one per unstalled
// cycle from the answer sequencer; the queue fills only in that burst or an output stall.
// Reset clears the parser, the queue and the sequencer and loads 192.168.4.1.
module captive_dns_responder #(
    parameter int MAX_PACKET = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        drop,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cdr_pkg::*;

    localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;

    logic [31:0] address_reg;
    logic        push, pop;
    cdr_rec_t    front_rec, head_rec;
    cdr_qstat_t  qstat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= ADDRESS_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            address_reg <= pwdata;
        end
    end

    assign in_stall = qstat.full;

    cdr_front #(.MAX_PACKET(MAX_PACKET)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .rec      (front_rec)
    );

    cdr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_rec),
        .pop    (pop),
        .rdata  (head_rec),
        .status (qstat)
    );

    cdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (head_rec),
        .qstat     (qstat),
        .pop       (pop),
        .address   (address_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .drop      (drop)
    );

endmodule

FILE: sv/cdr_checker.sv
// Port-level checker for the captive DNS responder and its bind.
`include "assert_macros.svh"

module cdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  in_byte,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        out_last,
    input logic        drop
);

    `CDR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "output valid dropped while stalled")
    `CDR_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_byte) && $stable(out_last) && $stable(drop), "stalled output changed")
    `CDR_ASSERT(a_drop_final, clk, rst_n, out_valid && drop |-> out_last, "drop on a result that is not final")
    `CDR_ASSERT_NEVER(a_stall_idle, clk, rst_n, in_stall && !out_valid, "input stalled while output is empty")

endmodule

bind captive_dns_responder cdr_checker u_cdr_checker (.*);

FILE: test/tb_captive_dns_responder.sv
// Self-checking testbench for the captive DNS responder: query byte streams in, predicted replies checked.
module tb_captive_dns_responder;
    timeunit 1ns;
    timeprecision 1ps;

    import cdr_pkg::*;

    localparam int MAX_PACKET = 512;
    localparam int PERIOD = 20;
    localparam int IDLE_PCT = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS = 14;
    localparam int LONG_PHASE_ITEMS = 40;
    localparam logic [31:0] ANSWER_RESET = 32'hC0A8_0401;
    localparam logic [2:0] ADDR_ANSWER_ADDRESS = 3'd0;

    typedef logic [7:0] byte_q_t[$];

    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_NAME,
        SCAN_TAIL
    } scan_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } reply_t;

    class dns_reply_scoreboard;
        logic [31:0] answer_addr;
        int unsigned nbytes;
        int unsigned q_end;
        scan_t scan;
        logic [7:0] label_left;
        logic [7:0] qd_hi;
        bit bad;
        reply_t replies[$];
        int unsigned faults;
        int unsigned checked;

        function new();
            answer_addr = ANSWER_RESET;
            faults = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            nbytes = 0;
            q_end = 0;
            scan = SCAN_HEADER;
            label_left = '0;
            qd_hi = '0;
            bad = 1'b0;
        endfunction

        function void fail(string msg);
            faults++;
            if (faults <= 10)
                $display("%s", msg);
        endfunction

        function void note_query_byte(logic [7:0] b, logic l);
            logic [7:0] o;
            logic [7:0] ans[ANSWER_LEN];
            bit keep;
            if (nbytes < MAX_PACKET)
            begin
                keep = 1'b0;
                o = b;
                case (scan)
                    SCAN_HEADER:
                    begin
                        keep = 1'b1;
                        case (nbytes)
                            2:
                            begin
                                if (b[7])
                                    bad = 1'b1;
                                o = b | QR_BIT | AA_BIT;
                            end
                            3: o = b | RA_BIT;
                            4: qd_hi = b;
                            5:
                            begin
                                if ({qd_hi, b} != 16'd1)
                                    bad = 1'b1;
                            end
                            6: o = 8'd0;
                            7: o = 8'd1;
                            default: ;
                        endcase
                        if (nbytes == HEADER_LEN - 1)
                            scan = SCAN_NAME;
                    end
                    SCAN_NAME:
                    begin
                        keep = 1'b1;
                        if (label_left != 0)
                            label_left--;
                        else if (b == 8'd0)
                        begin
                            q_end = nbytes + 5;
                            scan = SCAN_TAIL;
                        end
                        else if ((b & PTR_HI) == PTR_HI)
                        begin
                            q_end = nbytes + 6;
                            scan = SCAN_TAIL;
                        end
                        else
                            label_left = b;
                    end
                    default: keep = nbytes < q_end;
                endcase
                if (keep)
                    replies.push_back('{o, 1'b0, 1'b0});
                nbytes++;
            end
            if (l)
            begin
                if (bad || nbytes < HEADER_LEN || scan != SCAN_TAIL || q_end > nbytes ||
                    q_end + ANSWER_LEN > MAX_PACKET)
                    replies.push_back('{8'd0, 1'b1, 1'b1});
                else
                begin
                    ans = '{PTR_HI, PTR_LO, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, ANSWER_TTL,
                            8'd0, RDATA_LEN, answer_addr[31:24], answer_addr[23:16],
                            answer_addr[15:8], answer_addr[7:0]};
                    for (int i = 0; i < ANSWER_LEN; i++)
                        replies.push_back('{ans[i], i == ANSWER_LEN - 1, 1'b0});
                end
                restart();
            end
        endfunction

        function void check_reply_byte(logic [7:0] b, logic l, logic d);
            reply_t exp_r;
            if (replies.size() == 0)
                fail($sformatf("Unexpected reply transfer: data %02h last %0b drop %0b", b, l, d));
            else
            begin
                exp_r = replies.pop_front();
                if (exp_r.data !== b || exp_r.last !== l || exp_r.drop !== d)
                    fail($sformatf({"Reply %0d mismatch: expected data %02h last %0b drop %0b,",
                                    " got data %02h last %0b drop %0b"}, checked,
                                   exp_r.data, exp_r.last, exp_r.drop, b, l, d));
            end
            checked++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        drop;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    bit idle_on = 1'b1;
    int unsigned sent_items = 0;
    dns_reply_scoreboard sb = new();

    captive_dns_responder #(
        .MAX_PACKET(MAX_PACKET)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .out_last(out_last),
        .drop(drop),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_query_byte(in_byte, in_last);
            if (out_valid && !out_stall)
                sb.check_reply_byte(out_byte, out_last, drop);
        end
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic byte_q_t make_query(int name_len, bit use_ptr, int tail_len);
        byte_q_t pkt;
        int rem;
        int len;
        for (int i = 0; i < HEADER_LEN; i++)
            pkt.push_back(8'($urandom));
        pkt[2][7] = 1'b0;
        pkt[4] = 8'd0;
        pkt[5] = 8'd1;
        rem = (name_len == 1) ? 2 : name_len;
        while (rem > 0)
        begin
            if (rem > 64)
                len = (rem - 64 >= 2) ? 63 : 61;
            else
                len = rem - 1;
            pkt.push_back(8'(len));
            repeat (len) pkt.push_back(8'($urandom));
            rem -= len + 1;
        end
        if (use_ptr)
        begin
            pkt.push_back(PTR_HI | 8'($urandom_range(63)));
            pkt.push_back(8'($urandom));
        end
        else
            pkt.push_back(8'd0);
        repeat (4 + tail_len) pkt.push_back(8'($urandom));
        return pkt;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic l);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_packet(input byte_q_t pkt);
        sent_items += pkt.size();
        foreach (pkt[i])
            push_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_answer_address(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ANSWER_ADDRESS;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.answer_addr = value;
    endtask

    task automatic send_random_packet();
        byte_q_t pkt;
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        n = $urandom_range(8);
        pkt = make_query(n, $urandom_range(3) == 0, $urandom_range(3));
        if (pick >= 90)
        begin
            pkt.delete();
            repeat ($urandom_range(20, 1)) pkt.push_back(8'($urandom));
        end
        else if (pick >= 85)
        begin
            if ($urandom_range(1))
                pkt[2][7] = 1'b1;
            else
            begin
                pkt[4] = 8'($urandom);
                pkt[5] = 8'($urandom);
            end
        end
        else if (pick >= 78)
            repeat ($urandom_range(pkt.size() - 1, 1)) void'(pkt.pop_back());
        else if (pick >= 70)
            pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
        send_packet(pkt);
    endtask

    initial
    begin
        byte_q_t pkt;
        int unsigned phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Well-formed queries with the reset address.
        send_packet(make_query(0, 1'b0, 0));
        send_packet(make_query(2, 1'b1, 1));

        // A response and a wrong question count are dropped.
        pkt = make_query(0, 1'b0, 0);
        pkt[2] = pkt[2] | 8'h80;
        send_packet(pkt);
        pkt[2][7] = 1'b0;
        pkt[4] = 8'd1;
        send_packet(pkt);

        // A lone byte, a short header and a cut question.
        pkt = '{8'h12};
        send_packet(pkt);
        pkt = make_query(0, 1'b0, 0);
        while (pkt.size() > HEADER_LEN - 1)
            void'(pkt.pop_back());
        send_packet(pkt);
        pkt = make_query(0, 1'b0, 0);
        repeat (2) void'(pkt.pop_back());
        send_packet(pkt);

        // Length bytes with top bits 01 and 10 are plain label lengths.
        pkt = make_query(0, 1'b0, 0);
        while (pkt.size() > HEADER_LEN)
            void'(pkt.pop_back());
        pkt.push_back(8'h45);
        pkt.push_back(8'd0);
        repeat (4) pkt.push_back(8'($urandom));
        send_packet(pkt);
        while (pkt.size() > HEADER_LEN)
            void'(pkt.pop_back());
        pkt.push_back(8'h80);
        pkt.push_back(PTR_HI);
        pkt.push_back(PTR_LO);
        repeat (4) pkt.push_back(8'($urandom));
        send_packet(pkt);
        drain_replies();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_answer_address(32'h0000_0000);
                1: write_answer_address(32'hFFFF_FFFF);
                default: write_answer_address($urandom);
            endcase
            idle_on = (ph != 1);
            phase_end = sent_items + ((ph == 1) ? LONG_PHASE_ITEMS : PHASE_ITEMS);
            while (sent_items < phase_end)
                send_random_packet();
            drain_replies();
        end

        if (sb.faults == 0 && sb.replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/cdr_pkg.sv
sv/cdr_front.sv
sv/cdr_queue.sv
sv/cdr_back.sv
sv/captive_dns_responder.sv
sv/cdr_checker.sv
test/tb_captive_dns_responder.sv
